// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int CNT_W = 4;

    typedef enum logic [1:0] {
        REG_MATCH_PATTERN      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_TEXT   = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } sfr_reg_idx_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } sfr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_done;
    } sfr_out_t;

    // one burst of results produced by one input transaction
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             has_byte;
        logic             eos;
    } sfr_burst_ctl_t;

endpackage

// File: hw/rtl/sfr_window.sv
module sfr_window #(
    parameter int MAX_PATTERN_BYTES     = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8,
    parameter int BURST_BYTES           = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  sfr_pkg::sfr_in_t                   item,
    input  logic [MAX_PATTERN_BYTES*8-1:0]     pattern,
    input  logic [3:0]                         pattern_length,
    input  logic [MAX_REPLACEMENT_BYTES*8-1:0] replacement,
    input  logic [3:0]                         replacement_length,
    output logic [BURST_BYTES*8-1:0]           burst_bytes,
    output sfr_pkg::sfr_burst_ctl_t            burst_ctl
);
    import sfr_pkg::*;

    localparam int D = MAX_PATTERN_BYTES;

    logic [D-1:0][7:0] win_reg, win_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [D-1:0][7:0] pattern_b;
    logic [D-1:0][7:0] w2;
    logic [D-1:0][7:0] w3;
    logic [CNT_W-1:0]  c2;
    logic [CNT_W-1:0]  plen_eff;
    logic [CNT_W-1:0]  rlen_eff;
    logic [D-1:0]      match_ok;
    logic              full;
    logic              hit;

    assign pattern_b = pattern;

    always_comb
    begin
        if (pattern_length == '0)
            plen_eff = CNT_W'(1);
        else if (pattern_length > CNT_W'(MAX_PATTERN_BYTES))
            plen_eff = CNT_W'(MAX_PATTERN_BYTES);
        else
            plen_eff = pattern_length;

        if (replacement_length > CNT_W'(MAX_REPLACEMENT_BYTES))
            rlen_eff = CNT_W'(MAX_REPLACEMENT_BYTES);
        else
            rlen_eff = replacement_length;
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            w2[i]       = (CNT_W'(i) == cnt_reg) ? item.in_byte : win_reg[i];
            match_ok[i] = (CNT_W'(i) >= plen_eff) || (w2[i] == pattern_b[i]);
        end
        w3   = w2 >> 8;
        c2   = cnt_reg + CNT_W'(1);
        full = (c2 >= plen_eff);
        hit  = (c2 == plen_eff) && (&match_ok);
    end

    always_comb
    begin
        burst_ctl.eos      = item.end_of_stream;
        burst_ctl.has_byte = 1'b1;
        if (hit)
        begin
            burst_bytes     = (BURST_BYTES*8)'(replacement);
            burst_ctl.count = rlen_eff;
        end
        else
        begin
            burst_bytes = (BURST_BYTES*8)'(w2);
            if (item.end_of_stream)
                burst_ctl.count = c2;
            else if (full)
                burst_ctl.count = CNT_W'(1);
            else
                burst_ctl.count = '0;
        end
        if (item.end_of_stream && burst_ctl.count == '0)
        begin
            burst_ctl.count    = CNT_W'(1);
            burst_ctl.has_byte = 1'b0;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (fire)
        begin
            if (hit || item.end_of_stream)
            begin
                cnt_next = '0;
            end
            else if (full)
            begin
                win_next = w3;
                cnt_next = c2 - CNT_W'(1);
            end
            else
            begin
                win_next = w2;
                cnt_next = c2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// File: hw/rtl/sfr_burst.sv
module sfr_burst #(
    parameter int BURST_BYTES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [BURST_BYTES*8-1:0] load_bytes,
    input  sfr_pkg::sfr_burst_ctl_t  load_ctl,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sfr_pkg::sfr_out_t        out_data
);
    import sfr_pkg::*;

    localparam int IDX_W = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;

    logic                        valid_reg, valid_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [BURST_BYTES-1:0][7:0] bytes_reg, bytes_next;
    sfr_burst_ctl_t              ctl_reg, ctl_next;
    logic                        last;
    logic                        take;

    assign last      = (CNT_W'(idx_reg) + CNT_W'(1)) == ctl_reg.count;
    assign take      = valid_reg && out_ready;
    assign free      = !valid_reg || (out_ready && last);
    assign out_valid = valid_reg;

    always_comb
    begin
        out_data.out_byte    = ctl_reg.has_byte ? bytes_reg[idx_reg] : 8'h00;
        out_data.has_byte    = ctl_reg.has_byte;
        out_data.run_last    = last;
        out_data.stream_done = last && ctl_reg.eos;
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        bytes_next = bytes_reg;
        ctl_next   = ctl_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
            bytes_next = load_bytes;
            ctl_next   = load_ctl;
        end
        else if (take && last)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            ctl_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// File: hw/rtl/stream_find_replace.sv
// Streaming find-and-replace. Each input transaction is registered, then resolved against
// the pending-byte window combinationally into a burst of 0 to 8 results held in the
// output register, which hands out one result per cycle while out_ready is high. Plain
// bytes stream at one per cycle when the output does not stall; an input that causes
// several results (a replacement or an end-of-stream flush) holds the output register
// until its last result is taken. Configuration writes are taken at any time and are
// meant to happen only while the block is idle.
`include "assert_macros.svh"

module stream_find_replace #(
    parameter int MAX_PATTERN_BYTES     = 8,
    parameter int MAX_REPLACEMENT_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfr_pkg::sfr_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sfr_pkg::sfr_out_t  out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import sfr_pkg::*;

    localparam int BURST_BYTES = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                                 MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;

    logic [MAX_PATTERN_BYTES*8-1:0]     pattern_reg;
    logic [3:0]                         plen_reg;
    logic [MAX_REPLACEMENT_BYTES*8-1:0] repl_reg;
    logic [3:0]                         rlen_reg;

    logic                  inv_reg, inv_next;
    sfr_in_t               item_reg;
    logic                  burst_free;
    logic                  move;
    logic [BURST_BYTES*8-1:0] burst_bytes;
    sfr_burst_ctl_t        burst_ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sfr_reg_idx_t'(cfg_index))
                REG_MATCH_PATTERN:      pattern_reg <= cfg_data[MAX_PATTERN_BYTES*8-1:0];
                REG_PATTERN_LENGTH:     plen_reg    <= cfg_data[3:0];
                REG_REPLACEMENT_TEXT:   repl_reg    <= cfg_data[MAX_REPLACEMENT_BYTES*8-1:0];
                REG_REPLACEMENT_LENGTH: rlen_reg    <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    // input stage
    assign move     = inv_reg && burst_free;
    assign in_ready = !inv_reg || burst_free;

    always_comb
    begin
        if (in_valid && in_ready)
            inv_next = 1'b1;
        else if (move)
            inv_next = 1'b0;
        else
            inv_next = inv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_reg <= 1'b0;
        else
            inv_reg <= inv_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

    sfr_window #(
        .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES),
        .BURST_BYTES           (BURST_BYTES)
    ) u_window (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (move),
        .item               (item_reg),
        .pattern            (pattern_reg),
        .pattern_length     (plen_reg),
        .replacement        (repl_reg),
        .replacement_length (rlen_reg),
        .burst_bytes        (burst_bytes),
        .burst_ctl          (burst_ctl)
    );

    sfr_burst #(
        .BURST_BYTES (BURST_BYTES)
    ) u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (move && (burst_ctl.count != '0)),
        .load_bytes (burst_bytes),
        .load_ctl   (burst_ctl),
        .free       (burst_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    `ASSERT_IMPL(a_done_is_last, clk, rst_n, out_valid && out_data.stream_done,
                 out_data.run_last)
    `ASSERT_IMPL(a_marker_ends_stream, clk, rst_n, out_valid && !out_data.has_byte,
                 out_data.stream_done && out_data.run_last && out_data.out_byte == 8'h00)
    `ASSERT_IMPL(a_move_needs_room, clk, rst_n, move,
                 !out_valid || (out_ready && out_data.run_last))
    `ASSERT_NEXT(a_stalled_item_held, clk, rst_n, inv_reg && !move, inv_reg)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    sfr_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    sfr_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // shadow copy of the registers and the pending window
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len = 4'd1;
    logic [63:0] repl_bytes = '0;
    logic [3:0]  repl_len = 4'd0;
    logic [7:0]  win_bytes [8] = '{default: 8'h00};
    int          win_count = 0;

    sfr_out_t    replaced_stream_q [$];
    sfr_out_t    next_result;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int          rx_hold_cycles = 0;

    always #5 clk = ~clk;

    stream_find_replace u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int eff_pat_len();
        if (pat_len == 4'd0)
            return 1;
        if (pat_len > 4'd8)
            return 8;
        return int'(pat_len);
    endfunction

    function automatic sfr_out_t data_result(input logic [7:0] b);
        sfr_out_t r;
        r = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        return r;
    endfunction

    task automatic apply_find_replace(input logic [7:0] b, input logic eos);
        int       plen;
        int       rlen;
        bit       hit;
        sfr_out_t burst [$];
        plen = eff_pat_len();
        rlen = (repl_len > 4'd8) ? 8 : int'(repl_len);
        if (win_count < 8) begin
            win_bytes[win_count] = b;
            win_count++;
        end
        if (win_count >= plen) begin
            hit = (win_count == plen);
            for (int i = 0; i < plen; i++)
                if (win_bytes[i] != pat_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                for (int i = 0; i < rlen; i++)
                    burst.push_back(data_result(repl_bytes[8*i +: 8]));
                win_count = 0;
            end
            else begin
                burst.push_back(data_result(win_bytes[0]));
                for (int i = 1; i < 8; i++)
                    win_bytes[i-1] = win_bytes[i];
                win_bytes[7] = 8'h00;
                win_count--;
            end
        end
        if (eos) begin
            for (int i = 0; i < win_count; i++)
                burst.push_back(data_result(win_bytes[i]));
            win_count = 0;
            if (burst.size() == 0)
                burst.push_back('0);
            burst[burst.size()-1].stream_done = 1'b1;
        end
        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[i])
            replaced_stream_q.push_back(burst[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos);
        sfr_in_t item;
        item.in_byte = b;
        item.end_of_stream = eos;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_find_replace(b, eos);
    endtask

    task automatic cfg_write(input sfr_reg_idx_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        unique case (idx)
            REG_MATCH_PATTERN:      pat_bytes = value;
            REG_PATTERN_LENGTH:     pat_len = value[3:0];
            REG_REPLACEMENT_TEXT:   repl_bytes = value;
            REG_REPLACEMENT_LENGTH: repl_len = value[3:0];
            default: ;
        endcase
    endtask

    // length registers get random upper bits, only the low nibble counts
    task automatic program_regs(input logic [63:0] pat, input logic [3:0] plen,
                                input logic [63:0] repl, input logic [3:0] rlen);
        cfg_write(REG_MATCH_PATTERN, pat);
        cfg_write(REG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
        cfg_write(REG_REPLACEMENT_TEXT, repl);
        cfg_write(REG_REPLACEMENT_LENGTH, {$urandom, 28'($urandom), rlen});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (replaced_stream_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly pattern bytes in order so matches occur, broken up by random bytes
    task automatic send_stream(input int n, input bit close);
        int         plen;
        int         pos;
        logic [7:0] b;
        bit         eos;
        plen = eff_pat_len();
        pos = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                b = pat_bytes[8*(pos % plen) +: 8];
                pos++;
            end
            else begin
                b = 8'($urandom_range(0, 255));
                pos = 0;
            end
            eos = (close && k == n - 1) || $urandom_range(0, 24) == 0;
            send_byte(b, eos);
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b1);
        drain();
    endtask

    task automatic test_length_clamping();
        program_regs(64'h41, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        drain();
        program_regs('1, 4'd15, 64'h0, 4'd0);
        repeat (8) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
    endtask

    task automatic test_pattern_shortened_midstream();
        program_regs(64'h6463_6261, 4'd4, 64'h5A, 4'd1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b0);
        drain();
        program_regs(64'h7A, 4'd1, 64'h2A2A, 4'd2);
        send_byte(8'h71, 1'b0);
        send_byte(8'h7A, 1'b1);
        drain();
    endtask

    task automatic test_random_streams();
        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: program_regs({$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd8);
                1: program_regs({$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd0);
                default: program_regs({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                                      {$urandom, $urandom}, 4'($urandom_range(0, 15)));
            endcase
            send_stream(10, 1'b1);
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        program_regs(64'h5A, 4'd1, {$urandom, $urandom}, 4'd8);
        rx_hold_cycles = 150;
        send_stream(25, 1'b1);
        drain();
    endtask

    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        program_regs({$urandom, $urandom}, 4'd3, {$urandom, $urandom}, 4'd2);
        send_stream(20, 1'b1);
        drain();
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                out_ready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val,
                     act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (replaced_stream_q.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual %p", $time,
                         out_data);
                mismatch_count++;
            end
            else begin
                next_result = replaced_stream_q.pop_front();
                check_field("out_byte", next_result.out_byte, out_data.out_byte);
                check_field("has_byte", 8'(next_result.has_byte), 8'(out_data.has_byte));
                check_field("run_last", 8'(next_result.run_last), 8'(out_data.run_last));
                check_field("stream_done", 8'(next_result.stream_done),
                            8'(out_data.stream_done));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_reset_defaults();
        test_length_clamping();
        test_pattern_shortened_midstream();
        test_random_streams();
        test_output_backpressure();
        test_full_rate();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_window.sv
hw/rtl/sfr_burst.sv
hw/rtl/stream_find_replace.sv
tb/testbench.sv
